FILE: rtl/tdos_pkg.sv
// ----------------------------------------------------------------------------
// Train drive output shaper: shared definitions
// Types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tdos_pkg;

  // Q1.16 fractions: 65536 stands for 1.0.
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Quotient bits produced by the divider, one per step.
  localparam int unsigned DIV_STEPS = 16;

  // Short brake pulses are stretched to this many ticks at this code.
  localparam logic [7:0]  MIN_BRAKE_CYCLES = 8'd3;
  localparam logic [15:0] MIN_BRAKE_OUTPUT = 16'd4096;

  // The holding brake percent is turned into a fraction by this divisor.
  localparam logic [14:0] HOLD_PCT_DIV = 15'd100;

  // Percent * 65536 / 100 is taken as a multiply by 655.36 scaled by 2^16 and
  // rounded up, then a 16-bit shift; the result is exact for 0 to 100.
  localparam logic [6:0]  HOLD_PCT_FULL  = 7'd100;
  localparam logic [25:0] HOLD_PCT_RECIP = 26'd42949673;

  // Configuration port address width (eight registers at 4-byte spacing).
  localparam int unsigned CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_ANALOG_MIN     = 3'd0,
    REG_ANALOG_MAX     = 3'd1,
    REG_TRACTION_RISE  = 3'd2,
    REG_TRACTION_FALL  = 3'd3,
    REG_BRAKE_RISE     = 3'd4,
    REG_BRAKE_FALL     = 3'd5,
    REG_HOLD_SPEED     = 3'd6,
    REG_HOLD_PCT       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_COAST    = 2'd0,
    DIR_TRACTION = 2'd1,
    DIR_BRAKE    = 2'd2
  } dir_t;

  typedef struct packed {
    logic [15:0] analog_min;
    logic [15:0] analog_max;
    logic [15:0] traction_rise_step;
    logic [15:0] traction_fall_step;
    logic [15:0] brake_rise_step;
    logic [15:0] brake_fall_step;
    logic [16:0] hold_speed_bound;
    logic [6:0]  hold_brake_percent;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted input beat
    logic div_init;   // set up the divider
    logic div_step;   // one restoring-division step
    logic hold_pass;  // second pass: holding brake fraction and level
    logic mul;        // select fraction and multiply by the analog span
    logic lvl;        // add analog_min and fold into the drive level
    logic finish;     // slew limit, update state, load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a new result
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/train_drive_output_shaper_core.sv
// ----------------------------------------------------------------------------
// Train drive output shaper
// Turns an acceleration demand into drive direction, traction or brake
// fraction and a slew-limited analog drive code, once per control tick.
// ----------------------------------------------------------------------------
//
//  Port group | Role   | Beat contents
//  -----------+--------+-------------------------------------------------
//  in_*       | input  | demand, speed, traction/brake limits, cut flags
//  out_*      | output | direction (tuser), fractions, analog code, hold
//  cfg_*      | APB    | eight configuration registers at 4-byte spacing
//
//  Each beat passes through an accept state, divider setup and 16
//  divider steps, a multiply and a level step for the demand and again
//  for the holding brake, and a slew/output step. A new input beat is
//  taken as soon as the previous result sits in the output register;
//  the result step waits only while that register is full.
//  Reset is synchronous and needs no clearing pass.
//
`default_nettype none

module train_drive_output_shaper_core #(
  parameter logic [7:0]  BRAKE_MIN_CYCLES = tdos_pkg::MIN_BRAKE_CYCLES,
  parameter logic [15:0] BRAKE_MIN_OUTPUT = tdos_pkg::MIN_BRAKE_OUTPUT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [15:0] accel_demand, [31:16] train_speed, [46:32] max_traction_accel,
  // [61:47] max_brake_accel, [62] protection_cut, [63] operation_cut
  input  logic [63:0]                 in_tdata,
  // Result stream.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [16:0] traction_fraction, [33:17] brake_fraction, [49:34] analog_drive,
  // [50] hold_active, [55:51] zero
  output logic [55:0]                 out_tdata,
  // [1:0] drive_direction
  output logic [1:0]                  out_tuser,
  // Configuration port.
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tdos_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import tdos_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  stat_t       stat;
  dir_t        drive_direction;
  logic [16:0] traction_fraction;
  logic [16:0] brake_fraction;
  logic [15:0] analog_drive;
  logic        hold_active;

  assign cfg_pready = 1'b1;

  tdos_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  tdos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tdos_dp #(
    .BRAKE_MIN_CYCLES (BRAKE_MIN_CYCLES),
    .BRAKE_MIN_OUTPUT (BRAKE_MIN_OUTPUT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .accel_demand       (in_tdata[15:0]),
    .train_speed        (in_tdata[31:16]),
    .max_traction_accel (in_tdata[46:32]),
    .max_brake_accel    (in_tdata[61:47]),
    .protection_cut     (in_tdata[62]),
    .operation_cut      (in_tdata[63]),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .drive_direction    (drive_direction),
    .traction_fraction  (traction_fraction),
    .brake_fraction     (brake_fraction),
    .analog_drive       (analog_drive),
    .hold_active        (hold_active),
    .stat               (stat)
  );

  assign out_tdata = {5'd0, hold_active, analog_drive, brake_fraction, traction_fraction};
  assign out_tuser = drive_direction;

endmodule

`default_nettype wire

FILE: rtl/tdos_cfg.sv
// ----------------------------------------------------------------------------
// Train drive output shaper: configuration registers
// APB-style register file with write at the access phase and a read mux.
// ----------------------------------------------------------------------------
`default_nettype none

module tdos_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdos_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output tdos_pkg::cfg_t              cfg
);
  import tdos_pkg::*;

  cfg_t     regs_r;
  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.analog_min         <= 16'd0;
      regs_r.analog_max         <= 16'hFFFF;
      regs_r.traction_rise_step <= 16'hFFFF;
      regs_r.traction_fall_step <= 16'hFFFF;
      regs_r.brake_rise_step    <= 16'hFFFF;
      regs_r.brake_fall_step    <= 16'hFFFF;
      regs_r.hold_speed_bound   <= 17'd0;
      regs_r.hold_brake_percent <= 7'd0;
    end else if (wr_en) begin
      case (idx)
        REG_ANALOG_MIN:    regs_r.analog_min         <= pwdata[15:0];
        REG_ANALOG_MAX:    regs_r.analog_max         <= pwdata[15:0];
        REG_TRACTION_RISE: regs_r.traction_rise_step <= pwdata[15:0];
        REG_TRACTION_FALL: regs_r.traction_fall_step <= pwdata[15:0];
        REG_BRAKE_RISE:    regs_r.brake_rise_step    <= pwdata[15:0];
        REG_BRAKE_FALL:    regs_r.brake_fall_step    <= pwdata[15:0];
        REG_HOLD_SPEED:    regs_r.hold_speed_bound   <= pwdata[16:0];
        REG_HOLD_PCT:      regs_r.hold_brake_percent <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ANALOG_MIN:    prdata = {16'd0, regs_r.analog_min};
      REG_ANALOG_MAX:    prdata = {16'd0, regs_r.analog_max};
      REG_TRACTION_RISE: prdata = {16'd0, regs_r.traction_rise_step};
      REG_TRACTION_FALL: prdata = {16'd0, regs_r.traction_fall_step};
      REG_BRAKE_RISE:    prdata = {16'd0, regs_r.brake_rise_step};
      REG_BRAKE_FALL:    prdata = {16'd0, regs_r.brake_fall_step};
      REG_HOLD_SPEED:    prdata = {15'd0, regs_r.hold_speed_bound};
      REG_HOLD_PCT:      prdata = {25'd0, regs_r.hold_brake_percent};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = regs_r;

endmodule

`default_nettype wire

FILE: rtl/tdos_ctrl.sv
// ----------------------------------------------------------------------------
// Train drive output shaper: controller
// Sequences one divide and two multiply/level passes per beat, then the
// slew stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdos_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tdos_pkg::stat_t stat,
  output tdos_pkg::cmd_t  cmd
);
  import tdos_pkg::*;

  localparam int unsigned     CNT_W    = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DINIT,
    S_DIV,
    S_MUL,
    S_LVL,
    S_DONE
  } state_t;

  state_t           state_r;
  logic             pass_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pass_r  <= 1'b0;
            state_r <= S_DINIT;
          end
        end
        S_DINIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_LAST) begin
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MUL: begin
          state_r <= S_LVL;
        end
        S_LVL: begin
          // The first pass handles the demand, the second the holding brake.
          if (pass_r) begin
            state_r <= S_DONE;
          end else begin
            pass_r  <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (stat.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd.load      = in_valid & in_ready;
    cmd.div_init  = (state_r == S_DINIT);
    cmd.div_step  = (state_r == S_DIV);
    cmd.hold_pass = pass_r;
    cmd.mul       = (state_r == S_MUL);
    cmd.lvl       = (state_r == S_LVL);
    cmd.finish    = (state_r == S_DONE) & stat.out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/tdos_dp.sv
// ----------------------------------------------------------------------------
// Train drive output shaper: datapath
// Direction decision, restoring divider, holding brake fraction, span
// multiplier, holding brake merge, slew limiter, tick state and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdos_dp #(
  parameter logic [7:0]  BRAKE_MIN_CYCLES = tdos_pkg::MIN_BRAKE_CYCLES,
  parameter logic [15:0] BRAKE_MIN_OUTPUT = tdos_pkg::MIN_BRAKE_OUTPUT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tdos_pkg::cmd_t  cmd,
  input  tdos_pkg::cfg_t  cfg,
  input  logic [15:0]     accel_demand,
  input  logic [15:0]     train_speed,
  input  logic [14:0]     max_traction_accel,
  input  logic [14:0]     max_brake_accel,
  input  logic            protection_cut,
  input  logic            operation_cut,
  input  logic            out_ready,
  output logic            out_valid,
  output tdos_pkg::dir_t  drive_direction,
  output logic [16:0]     traction_fraction,
  output logic [16:0]     brake_fraction,
  output logic [15:0]     analog_drive,
  output logic            hold_active,
  output tdos_pkg::stat_t stat
);
  import tdos_pkg::*;

  // Per-beat registers.
  dir_t        dir0_r;
  logic        dem_r;
  logic        stretch_r;
  logic        hold_r;
  logic [15:0] mag_r;
  logic [14:0] maxv_r;
  logic [16:0] hold_frac_r;

  // Divider.
  logic [15:0] rem_r;
  logic [14:0] dvs_r;
  logic [15:0] quo_r;
  logic        cap_r;
  logic        zero_r;

  // Fractions, product and drive level.
  logic [16:0] frac_r;
  logic [16:0] frac1_r;
  logic [16:0] hfrac_r;
  logic [32:0] prod_r;
  logic [15:0] analog_r;

  // Tick-to-tick state.
  logic [15:0] last_analog_r;
  dir_t        last_dir_r;
  logic [7:0]  run_cnt_r;

  // Output register.
  logic        out_valid_r;
  dir_t        out_dir_r;
  logic [16:0] out_tfrac_r;
  logic [16:0] out_bfrac_r;
  logic [15:0] out_analog_r;
  logic        out_hold_r;

  // Load decision.
  logic        positive;
  logic        negative;
  logic        stretch_ok;
  logic [7:0]  run_inc;
  logic [15:0] neg_mag;
  dir_t        dir0_nxt;
  logic        hold_nxt;
  logic [6:0]  hold_pct;
  logic [32:0] hold_prod;
  logic [16:0] hold_frac;

  // Divider and multiplier logic.
  logic [15:0] rem_init;
  logic [14:0] dvs_init;
  logic [16:0] rem2;
  logic [16:0] div_frac;
  logic [16:0] fsel;
  logic [15:0] span;
  logic [16:0] level_sum;
  logic [15:0] level;

  // Slew limiter.
  dir_t        dir_f;
  logic        rising;
  logic [15:0] step;
  logic [15:0] fall_max;
  logic [15:0] up_diff;
  logic [15:0] dn_diff;
  logic [15:0] slew_res;

  always_comb begin
    positive   = (accel_demand != 16'd0) && !accel_demand[15] &&
                 !(protection_cut | operation_cut);
    negative   = accel_demand[15];
    stretch_ok = (last_dir_r == DIR_BRAKE) && (run_cnt_r != 8'd0) &&
                 (run_cnt_r < BRAKE_MIN_CYCLES);
    run_inc    = (run_cnt_r == 8'hFF) ? run_cnt_r : run_cnt_r + 8'd1;
    neg_mag    = ~accel_demand + 16'd1;
    if (positive) begin
      dir0_nxt = DIR_TRACTION;
    end else if (negative || stretch_ok) begin
      dir0_nxt = DIR_BRAKE;
    end else begin
      dir0_nxt = DIR_COAST;
    end
    hold_nxt = (cfg.hold_speed_bound != 17'd0) &&
               ({1'b0, train_speed} < cfg.hold_speed_bound) &&
               (dir0_nxt != DIR_TRACTION);
    // Percents above hundred count as hundred.
    hold_pct  = (cfg.hold_brake_percent > HOLD_PCT_FULL) ?
                HOLD_PCT_FULL : cfg.hold_brake_percent;
    hold_prod = 33'(hold_pct) * 33'(HOLD_PCT_RECIP);
    hold_frac = hold_prod[32:16];
  end

  always_comb begin
    rem_init = mag_r;
    dvs_init = maxv_r;
    rem2 = {rem_r, 1'b0};
    if (zero_r) begin
      div_frac = 17'd0;
    end else if (cap_r) begin
      div_frac = FRAC_ONE;
    end else begin
      div_frac = {1'b0, quo_r};
    end
    // The holding brake raises the brake fraction, never lowers it.
    if (cmd.hold_pass) begin
      fsel = (hold_frac_r > frac1_r) ? hold_frac_r : frac1_r;
    end else begin
      fsel = dem_r ? div_frac : 17'd0;
    end
    span      = (cfg.analog_max > cfg.analog_min) ?
                cfg.analog_max - cfg.analog_min : 16'd0;
    level_sum = {1'b0, cfg.analog_min} + prod_r[32:16];
    level     = level_sum[15:0];
  end

  always_comb begin
    dir_f    = hold_r ? DIR_BRAKE : dir0_r;
    rising   = analog_r >= last_analog_r;
    fall_max = (cfg.traction_fall_step > cfg.brake_fall_step) ?
               cfg.traction_fall_step : cfg.brake_fall_step;
    case (dir_f)
      DIR_TRACTION: step = rising ? cfg.traction_rise_step : cfg.traction_fall_step;
      DIR_BRAKE:    step = rising ? cfg.brake_rise_step : cfg.brake_fall_step;
      default:      step = fall_max;
    endcase
    up_diff = analog_r - last_analog_r;
    dn_diff = last_analog_r - analog_r;
    if (rising && (up_diff >= step)) begin
      slew_res = last_analog_r + step;
    end else if ((last_analog_r >= analog_r) && (dn_diff >= step)) begin
      slew_res = last_analog_r - step;
    end else begin
      slew_res = analog_r;
    end
  end

  // Beat capture and the brake run counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= 8'd0;
    end else if (cmd.load) begin
      if (positive) begin
        run_cnt_r <= 8'd0;
      end else if (negative || stretch_ok) begin
        run_cnt_r <= run_inc;
      end else begin
        run_cnt_r <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir0_r      <= dir0_nxt;
      dem_r       <= positive | negative;
      stretch_r   <= !positive && !negative && stretch_ok;
      hold_r      <= hold_nxt;
      mag_r       <= positive ? accel_demand : neg_mag;
      maxv_r      <= positive ? max_traction_accel : max_brake_accel;
      hold_frac_r <= hold_frac;
    end
  end

  // Restoring division; the quotient only matters when it stays below one.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= rem_init;
      dvs_r  <= dvs_init;
      quo_r  <= 16'd0;
      cap_r  <= rem_init >= {1'b0, dvs_init};
      zero_r <= (dvs_init == 15'd0);
    end else if (cmd.div_step) begin
      if (rem2 >= {2'b0, dvs_r}) begin
        rem_r <= rem2[15:0] - {1'b0, dvs_r};
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= rem2[15:0];
        quo_r <= {quo_r[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      frac_r <= fsel;
      prod_r <= 33'(span) * 33'(fsel);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl) begin
      if (!cmd.hold_pass) begin
        frac1_r <= frac_r;
        if (dem_r) begin
          analog_r <= level;
        end else if (stretch_r) begin
          analog_r <= BRAKE_MIN_OUTPUT;
        end else begin
          analog_r <= 16'd0;
        end
      end else if (hold_r) begin
        hfrac_r <= frac_r;
        if (level > analog_r) begin
          analog_r <= level;
        end
      end
    end
  end

  // Tick state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_analog_r <= 16'd0;
      last_dir_r    <= DIR_COAST;
      out_valid_r   <= 1'b0;
    end else if (cmd.finish) begin
      last_analog_r <= slew_res;
      last_dir_r    <= dir_f;
      out_valid_r   <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_dir_r    <= dir_f;
      out_tfrac_r  <= (dir0_r == DIR_TRACTION) ? frac1_r : 17'd0;
      out_analog_r <= slew_res;
      out_hold_r   <= hold_r;
      if (hold_r) begin
        out_bfrac_r <= hfrac_r;
      end else begin
        out_bfrac_r <= (dir0_r == DIR_BRAKE) ? frac1_r : 17'd0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign drive_direction   = out_dir_r;
  assign traction_fraction = out_tfrac_r;
  assign brake_fraction    = out_bfrac_r;
  assign analog_drive      = out_analog_r;
  assign hold_active       = out_hold_r;
  assign stat.out_free     = !out_valid_r || out_ready;

endmodule

`default_nettype wire

FILE: tb/tdos_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Train drive output shaper: result checker
// Watches the configuration port and both streams. It keeps its own copy of
// the registers and the tick-to-tick state, works out the result of every
// accepted input beat and compares each result beat, field by field, with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module tdos_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [63:0]                 in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [55:0]                 out_tdata,
  input  logic [1:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tdos_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  input  logic                        cfg_pready,
  output int unsigned                 ticks_pending,
  output int unsigned                 mismatch_count
);
  import tdos_pkg::*;

  typedef struct {
    dir_t        dir;
    logic [16:0] tfrac;
    logic [16:0] bfrac;
    logic [15:0] drive;
    logic        hold;
  } tick_result_t;

  cfg_t         shadow;
  logic [15:0]  drive_level;
  dir_t         prev_dir;
  logic [7:0]   brake_ticks;
  tick_result_t expected_ticks[$];

  initial begin
    ticks_pending = 0;
    mismatch_count = 0;
  end

  function automatic logic [16:0] q16_fraction(input logic [16:0] mag, input logic [14:0] limit);
    logic [32:0] q;
    if (limit == 15'd0) return 17'd0;
    q = {mag, 16'h0000} / limit;
    return (q > FRAC_ONE) ? FRAC_ONE : q[16:0];
  endfunction

  // An inverted analog range collapses to analog_min.
  function automatic logic [15:0] analog_level(input logic [16:0] frac);
    logic [15:0] span;
    logic [32:0] scaled;
    span = (shadow.analog_max > shadow.analog_min) ?
           shadow.analog_max - shadow.analog_min : 16'd0;
    scaled = span * frac;
    return shadow.analog_min + scaled[31:16];
  endfunction

  function automatic tick_result_t predict_tick(input logic [63:0] beat);
    logic [15:0]  demand;
    logic [15:0]  speed;
    logic [14:0]  lim_tr;
    logic [14:0]  lim_br;
    logic         pushing;
    logic [15:0]  target;
    logic [15:0]  step;
    logic [6:0]   pct;
    logic [16:0]  hold_frac;
    logic [15:0]  hold_level;
    tick_result_t r;
    demand  = beat[15:0];
    speed   = beat[31:16];
    lim_tr  = beat[46:32];
    lim_br  = beat[61:47];
    pushing = (demand != 16'd0) && !demand[15] && !(beat[62] | beat[63]);
    r.dir   = DIR_COAST;
    r.tfrac = '0;
    r.bfrac = '0;
    r.hold  = 1'b0;
    target  = '0;

    if (pushing) begin
      r.dir = DIR_TRACTION;
      r.tfrac = q16_fraction({1'b0, demand}, lim_tr);
      target = analog_level(r.tfrac);
      brake_ticks = '0;
    end else if (demand[15]) begin
      r.dir = DIR_BRAKE;
      r.bfrac = q16_fraction(17'h10000 - {1'b0, demand}, lim_br);
      target = analog_level(r.bfrac);
      if (brake_ticks != 8'hFF) brake_ticks++;
    end else if (prev_dir == DIR_BRAKE && brake_ticks != 8'd0 &&
                 brake_ticks < MIN_BRAKE_CYCLES) begin
      // A brake run that ended too early is held at the minimum output.
      r.dir = DIR_BRAKE;
      target = MIN_BRAKE_OUTPUT;
      brake_ticks++;
    end else begin
      brake_ticks = '0;
    end

    if (shadow.hold_speed_bound != 17'd0 && {1'b0, speed} < shadow.hold_speed_bound &&
        r.dir != DIR_TRACTION) begin
      pct = (shadow.hold_brake_percent > 7'd100) ? 7'd100 : shadow.hold_brake_percent;
      hold_frac = 17'(({pct, 16'h0000}) / HOLD_PCT_DIV);
      r.dir = DIR_BRAKE;
      r.hold = 1'b1;
      if (hold_frac > r.bfrac) r.bfrac = hold_frac;
      hold_level = analog_level(r.bfrac);
      if (hold_level > target) target = hold_level;
    end

    if (r.dir == DIR_TRACTION) begin
      step = (target >= drive_level) ? shadow.traction_rise_step : shadow.traction_fall_step;
    end else if (r.dir == DIR_BRAKE) begin
      step = (target >= drive_level) ? shadow.brake_rise_step : shadow.brake_fall_step;
    end else begin
      step = (shadow.traction_fall_step > shadow.brake_fall_step) ?
             shadow.traction_fall_step : shadow.brake_fall_step;
    end

    if (target >= drive_level && target - drive_level >= step) begin
      r.drive = drive_level + step;
    end else if (drive_level >= target && drive_level - target >= step) begin
      r.drive = drive_level - step;
    end else begin
      r.drive = target;
    end

    drive_level = r.drive;
    prev_dir = r.dir;
    return r;
  endfunction

  task automatic flag(input string what, input longint unsigned want, input longint unsigned got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    tick_result_t want;
    if (!rst_n) begin
      shadow.analog_min         = 16'd0;
      shadow.analog_max         = 16'hFFFF;
      shadow.traction_rise_step = 16'hFFFF;
      shadow.traction_fall_step = 16'hFFFF;
      shadow.brake_rise_step    = 16'hFFFF;
      shadow.brake_fall_step    = 16'hFFFF;
      shadow.hold_speed_bound   = 17'd0;
      shadow.hold_brake_percent = 7'd0;
      drive_level = 16'd0;
      prev_dir    = DIR_COAST;
      brake_ticks = 8'd0;
      expected_ticks.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_ANALOG_MIN:    shadow.analog_min         = cfg_pwdata[15:0];
          REG_ANALOG_MAX:    shadow.analog_max         = cfg_pwdata[15:0];
          REG_TRACTION_RISE: shadow.traction_rise_step = cfg_pwdata[15:0];
          REG_TRACTION_FALL: shadow.traction_fall_step = cfg_pwdata[15:0];
          REG_BRAKE_RISE:    shadow.brake_rise_step    = cfg_pwdata[15:0];
          REG_BRAKE_FALL:    shadow.brake_fall_step    = cfg_pwdata[15:0];
          REG_HOLD_SPEED:    shadow.hold_speed_bound   = cfg_pwdata[16:0];
          REG_HOLD_PCT:      shadow.hold_brake_percent = cfg_pwdata[6:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        if (expected_ticks.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected, tdata %h tuser %0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_ticks.pop_front();
          if (out_tuser !== want.dir) flag("drive_direction", want.dir, out_tuser);
          if (out_tdata[16:0] !== want.tfrac) flag("traction_fraction", want.tfrac, out_tdata[16:0]);
          if (out_tdata[33:17] !== want.bfrac) flag("brake_fraction", want.bfrac, out_tdata[33:17]);
          if (out_tdata[49:34] !== want.drive) flag("analog_drive", want.drive, out_tdata[49:34]);
          if (out_tdata[50] !== want.hold) flag("hold_active", want.hold, out_tdata[50]);
          if (out_tdata[55:51] !== 5'd0) flag("tdata padding", 0, out_tdata[55:51]);
        end
      end

      if (in_tvalid && in_tready) begin
        expected_ticks.push_back(predict_tick(in_tdata));
      end
    end
    ticks_pending = expected_ticks.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Train drive output shaper: testbench top
// Drives reset, register settings and control ticks into the shaper: a short
// directed sequence first, then phases of random ticks under varied settings,
// with random gaps on both streams. The checker beside the block does the
// comparing; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;
  import tdos_pkg::*;

  typedef enum int {TICK_TRACTION, TICK_BRAKE, TICK_COAST, TICK_NOISE} tick_kind_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [63:0]        in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [55:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int unsigned        ticks_pending;
  int unsigned        mismatches;

  int unsigned        ticks_sent;
  int unsigned        send_gap_pct;
  int unsigned        recv_gap_pct;

  train_drive_output_shaper_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tdos_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .ticks_pending  (ticks_pending),
    .mismatch_count (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] pack_tick(input int demand, input int speed,
                                            input int lim_tr, input int lim_br,
                                            input bit prot_cut, input bit op_cut);
    return {op_cut, prot_cut, 15'(lim_br), 15'(lim_tr), 16'(speed), 16'(demand)};
  endfunction

  // Idling changes over the run: sender light and receiver heavy, then the
  // other way round, then none at all.
  task automatic send_tick(input logic [63:0] beat);
    if (ticks_sent < 250) begin
      send_gap_pct = 15;
      recv_gap_pct = 49;
    end else if (ticks_sent < 500) begin
      send_gap_pct = 49;
      recv_gap_pct = 15;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Registers change only once every tick in flight has come back.
  task automatic write_settings(input int unsigned amin, input int unsigned amax,
                                input int unsigned tr_rise, input int unsigned tr_fall,
                                input int unsigned br_rise, input int unsigned br_fall,
                                input int unsigned bound, input int unsigned pct);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (ticks_pending != 0) @(negedge clk);
    cfg_write(REG_ANALOG_MIN, amin);
    cfg_write(REG_ANALOG_MAX, amax);
    cfg_write(REG_TRACTION_RISE, tr_rise);
    cfg_write(REG_TRACTION_FALL, tr_fall);
    cfg_write(REG_BRAKE_RISE, br_rise);
    cfg_write(REG_BRAKE_FALL, br_fall);
    cfg_write(REG_HOLD_SPEED, bound);
    cfg_write(REG_HOLD_PCT, pct);
  endtask

  function automatic int unsigned rand_limit();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32767;
      2, 3:    return $urandom_range(1, 2000);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  function automatic int unsigned rand_speed();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2, 3:    return $urandom_range(0, 3000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Magnitudes mostly land near the limit so that fractions are not all capped.
  function automatic int unsigned rand_mag(input int unsigned limit, input int unsigned ceiling);
    int unsigned upper;
    upper = limit + limit / 4 + 1;
    if (upper > ceiling) upper = ceiling;
    case ($urandom_range(0, 5))
      0:       return ceiling;
      1:       return 1;
      default: return $urandom_range(1, upper);
    endcase
  endfunction

  function automatic int unsigned rand_step();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65535;
      2, 3:    return $urandom_range(1, 2000);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic send_random_tick(input tick_kind_t kind);
    int unsigned lim_tr;
    int unsigned lim_br;
    int unsigned speed;
    int          demand;
    bit          prot_cut;
    bit          op_cut;
    lim_tr = rand_limit();
    lim_br = rand_limit();
    speed = rand_speed();
    prot_cut = ($urandom_range(0, 9) == 0);
    op_cut = ($urandom_range(0, 9) == 0);
    case (kind)
      TICK_TRACTION: demand = rand_mag(lim_tr, 32767);
      TICK_BRAKE:    demand = -int'(rand_mag(lim_br, 32768));
      TICK_COAST: begin
        // Some coast ticks are positive demands that a cut turns away.
        if ($urandom_range(0, 3) == 0) begin
          demand = rand_mag(lim_tr, 32767);
          if ($urandom_range(0, 1) == 0) prot_cut = 1'b1;
          else op_cut = 1'b1;
        end else begin
          demand = 0;
        end
      end
      default: begin
        send_tick({$urandom, $urandom});
        return;
      end
    endcase
    send_tick(pack_tick(demand, speed, lim_tr, lim_br, prot_cut, op_cut));
  endtask

  task automatic run_mixed_ticks(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    int unsigned run_len;
    int unsigned coast_len;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 9);
      run_len = $urandom_range(1, 4);
      coast_len = 0;
      if (pick < 3) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_random_tick(TICK_TRACTION);
      end else if (pick < 6) begin
        // Short brake runs ending in coast reach the pulse stretch.
        coast_len = $urandom_range(1, 3);
        repeat (run_len) send_random_tick(TICK_BRAKE);
        repeat (coast_len) send_random_tick(TICK_COAST);
      end else if (pick < 8) begin
        run_len = $urandom_range(1, 3);
        repeat (run_len) send_random_tick(TICK_COAST);
      end else if (pick < 9) begin
        repeat (run_len) send_random_tick(tick_kind_t'($urandom_range(0, 2)));
      end else begin
        run_len = 1;
        send_random_tick(TICK_NOISE);
      end
      done += run_len + coast_len;
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned amin;
    int unsigned amax;
    int unsigned bound;
    int unsigned pct;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    ticks_sent = 0;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed ticks: holding brake below speed 200 at 40 percent, no slew.
    write_settings(1000, 61000, 65535, 65535, 65535, 65535, 200, 40);
    send_tick(pack_tick(0, 65535, 0, 0, 0, 0));
    send_tick(pack_tick(32767, 1000, 32767, 0, 0, 0));
    send_tick(pack_tick(1, 1000, 0, 32767, 0, 0));
    send_tick(pack_tick(16384, 1000, 32767, 32767, 0, 0));
    send_tick(pack_tick(100, 1000, 50, 0, 0, 0));
    send_tick(pack_tick(5000, 1000, 10000, 0, 1, 0));
    send_tick(pack_tick(5000, 1000, 10000, 0, 0, 1));
    send_tick(pack_tick(5000, 1000, 10000, 0, 1, 1));
    send_tick(pack_tick(-32768, 1000, 0, 32767, 0, 0));
    send_tick(pack_tick(0, 1000, 0, 0, 0, 0));
    send_tick(pack_tick(0, 1000, 0, 0, 0, 0));
    send_tick(pack_tick(0, 1000, 0, 0, 0, 0));
    send_tick(pack_tick(-1, 1000, 0, 0, 0, 0));
    send_tick(pack_tick(-16384, 1000, 0, 32767, 0, 0));
    send_tick(pack_tick(1000, 1000, 2000, 0, 0, 0));
    send_tick(pack_tick(0, 1000, 0, 0, 0, 0));
    send_tick(pack_tick(-300, 1000, 0, 1000, 0, 0));
    send_tick(pack_tick(0, 5, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 0, 0, 0, 0));
    send_tick(pack_tick(2000, 0, 4000, 0, 0, 0));
    send_tick(pack_tick(-100, 199, 0, 32767, 0, 0));

    // Inverted analog range, percent above hundred, hold at every speed, slew.
    write_settings(50000, 100, 700, 900, 1100, 1300, 65536, 127);
    send_tick(pack_tick(0, 65535, 0, 0, 0, 0));
    send_tick(pack_tick(32767, 65535, 32767, 32767, 0, 0));
    send_tick(pack_tick(-32768, 0, 32767, 32767, 1, 1));

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_settings(0, 65535, 65535, 65535, 65535, 65535, 0, 0);
        1: write_settings(0, 65535, 1, 1, 1, 1, 65536, 100);
        4: write_settings(2000, 50000, 3000, 3000, 3000, 3000, 0, 0);
        default: begin
          amin = $urandom_range(0, 30000);
          amax = $urandom_range(amin, 65535);
          if ($urandom_range(0, 4) == 0) begin
            amin = $urandom_range(0, 65535);
            amax = $urandom_range(0, 65535);
          end
          case ($urandom_range(0, 3))
            0:       bound = 0;
            1:       bound = 65536;
            2:       bound = $urandom_range(1, 3000);
            default: bound = $urandom_range(1, 65536);
          endcase
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 100;
            2:       pct = $urandom_range(101, 127);
            default: pct = $urandom_range(0, 100);
          endcase
          write_settings(amin, amax, rand_step(), rand_step(), rand_step(), rand_step(),
                         bound, pct);
        end
      endcase
      if (ph == 4) begin
        // A brake run long enough that the run counter must saturate.
        repeat (258) send_random_tick(TICK_BRAKE);
        repeat (3) send_random_tick(TICK_COAST);
      end else begin
        run_mixed_ticks((ph < 4) ? 70 : 60);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (ticks_pending != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: train_drive_output_shaper_core.f
rtl/tdos_pkg.sv
rtl/tdos_cfg.sv
rtl/tdos_ctrl.sv
rtl/tdos_dp.sv
rtl/train_drive_output_shaper_core.sv
tb/tdos_checker.sv
tb/tb.sv
